>>> rtl/tls_pkg.sv
// Shared types and constants of the traffic light sequencer.
`default_nettype none

package tls_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned IdxW = 3;

  localparam logic [CntW-1:0] CNT_MAX = {CntW{1'b1}};

  // Register indexes on the configuration port
  localparam logic [IdxW-1:0] REG_RED_MS            = 3'd0;
  localparam logic [IdxW-1:0] REG_READY_YELLOW_MS   = 3'd1;
  localparam logic [IdxW-1:0] REG_GREEN_MS          = 3'd2;
  localparam logic [IdxW-1:0] REG_CAUTION_YELLOW_MS = 3'd3;
  localparam logic [IdxW-1:0] REG_BEEP_PERIOD_MS    = 3'd4;
  localparam logic [IdxW-1:0] REG_BEEP_LENGTH_MS    = 3'd5;

  // Reset values of the registers
  localparam logic [CntW-1:0] RST_RED_MS            = 16'd5000;
  localparam logic [CntW-1:0] RST_READY_YELLOW_MS   = 16'd2000;
  localparam logic [CntW-1:0] RST_GREEN_MS          = 16'd5000;
  localparam logic [CntW-1:0] RST_CAUTION_YELLOW_MS = 16'd2000;
  localparam logic [CntW-1:0] RST_BEEP_PERIOD_MS    = 16'd1000;
  localparam logic [CntW-1:0] RST_BEEP_LENGTH_MS    = 16'd200;

  typedef enum logic [1:0] {
    PH_RED            = 2'd0,
    PH_READY_YELLOW   = 2'd1,
    PH_GREEN          = 2'd2,
    PH_CAUTION_YELLOW = 2'd3
  } phase_t;

  // One result held in the output stage or the skid stage
  typedef struct packed {
    phase_t phase;
    logic   buzzer;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/traffic_light_sequencer_core.sv
// Top level of the traffic light sequencer: phase timer, beeper and output stage.
`default_nettype none

// Four-phase traffic light (red, ready yellow, green, caution yellow) with a
// pedestrian beeper during green. Each input transfer carries time_step: 1
// advances time by one millisecond before the step is evaluated, 0 evaluates
// without time passing. Every input transfer yields exactly one result
// transfer with the phase after the step, the three lamps and the buzzer.
// Rate: one item per clock cycle while in_stall is low; each result is
// registered into the output register, or into the skid entry while the
// presented result is stalled. The phase and beep counters are updated in
// the same cycle the item is taken, so items follow each other with no gap.
// The output side is an output register plus one skid entry; in_stall
// rises only when both hold results, i.e. once an input transfer arrives
// while the presented result is stalled, and it is driven from a register only.
// Configuration writes are taken at any time on cfg_we; change registers
// only while no result is outstanding. Writes to indexes beyond the six
// registers are dropped. Counters saturate at 65535.
module traffic_light_sequencer_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // input channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      time_step,
  // output channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     phase_code,
  output logic                           red_lamp,
  output logic                           yellow_lamp,
  output logic                           green_lamp,
  output logic                           buzzer_on,
  // configuration write port
  input  wire logic                      cfg_we,
  input  wire logic [tls_pkg::IdxW-1:0]  cfg_index,
  input  wire logic [tls_pkg::CntW-1:0]  cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [tls_pkg::CntW-1:0] red_ms;
  logic [tls_pkg::CntW-1:0] ready_yellow_ms;
  logic [tls_pkg::CntW-1:0] green_ms;
  logic [tls_pkg::CntW-1:0] caution_yellow_ms;
  logic [tls_pkg::CntW-1:0] beep_period_ms;
  logic [tls_pkg::CntW-1:0] beep_length_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_ms            <= tls_pkg::RST_RED_MS;
      ready_yellow_ms   <= tls_pkg::RST_READY_YELLOW_MS;
      green_ms          <= tls_pkg::RST_GREEN_MS;
      caution_yellow_ms <= tls_pkg::RST_CAUTION_YELLOW_MS;
      beep_period_ms    <= tls_pkg::RST_BEEP_PERIOD_MS;
      beep_length_ms    <= tls_pkg::RST_BEEP_LENGTH_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        tls_pkg::REG_RED_MS:            red_ms            <= cfg_data;
        tls_pkg::REG_READY_YELLOW_MS:   ready_yellow_ms   <= cfg_data;
        tls_pkg::REG_GREEN_MS:          green_ms          <= cfg_data;
        tls_pkg::REG_CAUTION_YELLOW_MS: caution_yellow_ms <= cfg_data;
        tls_pkg::REG_BEEP_PERIOD_MS:    beep_period_ms    <= cfg_data;
        tls_pkg::REG_BEEP_LENGTH_MS:    beep_length_ms    <= cfg_data;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  tls_pkg::phase_t          phase, phase_next;
  logic [tls_pkg::CntW-1:0] phase_elapsed, phase_elapsed_next;
  logic [tls_pkg::CntW-1:0] since_beep, since_beep_next;
  logic                     beep_started, beep_started_next;
  logic                     buzzer_active, buzzer_active_next;

  logic                     in_xfer;
  logic                     out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Time advance, saturating at the counter ceiling
  logic [tls_pkg::CntW-1:0] elapsed_adv;
  logic [tls_pkg::CntW-1:0] since_adv;
  logic [tls_pkg::CntW-1:0] phase_len;
  logic                     phase_done;

  always_comb begin
    elapsed_adv = phase_elapsed;
    if (time_step && (phase_elapsed != tls_pkg::CNT_MAX)) begin
      elapsed_adv = phase_elapsed + 16'd1;
    end
    since_adv = since_beep;
    if (time_step && beep_started && (since_beep != tls_pkg::CNT_MAX)) begin
      since_adv = since_beep + 16'd1;
    end
  end

  // Length of the current phase
  always_comb begin
    case (phase)
      tls_pkg::PH_RED:          phase_len = red_ms;
      tls_pkg::PH_READY_YELLOW: phase_len = ready_yellow_ms;
      tls_pkg::PH_GREEN:        phase_len = green_ms;
      default:                  phase_len = caution_yellow_ms;
    endcase
  end

  assign phase_done = (elapsed_adv >= phase_len);

  // Next phase: advance one phase when the current one has run out
  always_comb begin
    phase_next = phase;
    if (phase_done) begin
      phase_next = tls_pkg::phase_t'(phase + 2'd1);
    end
  end

  // Counters and beeper
  always_comb begin
    logic start_beep;
    start_beep         = 1'b0;
    phase_elapsed_next = elapsed_adv;
    since_beep_next    = since_adv;
    beep_started_next  = beep_started;
    buzzer_active_next = buzzer_active;
    if (phase == tls_pkg::PH_GREEN) begin
      start_beep = !beep_started || (since_adv >= beep_period_ms);
      if (start_beep) begin
        buzzer_active_next = 1'b1;
        since_beep_next    = '0;
        beep_started_next  = 1'b1;
      end
      // end the beep once it has lasted its length (same step if zero)
      if (buzzer_active_next && (since_beep_next >= beep_length_ms)) begin
        buzzer_active_next = 1'b0;
      end
    end
    // leaving a phase silences the buzzer and clears its timer
    if (phase_done) begin
      phase_elapsed_next = '0;
      since_beep_next    = '0;
      beep_started_next  = 1'b0;
      buzzer_active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tls_pkg::PH_RED;
      phase_elapsed <= '0;
      since_beep    <= '0;
      beep_started  <= 1'b0;
      buzzer_active <= 1'b0;
    end else if (in_xfer) begin
      phase         <= phase_next;
      phase_elapsed <= phase_elapsed_next;
      since_beep    <= since_beep_next;
      beep_started  <= beep_started_next;
      buzzer_active <= buzzer_active_next;
    end
  end

  // ---------------------------------------------------------------------
  // Output register with one skid entry
  // ---------------------------------------------------------------------
  tls_pkg::result_t result_new;
  tls_pkg::result_t out_res;
  tls_pkg::result_t skid_res;
  logic             skid_valid;

  assign result_new = '{phase: phase_next, buzzer: buzzer_active_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // input is held off; drain the skid entry into the output register
      if (out_xfer) begin
        skid_valid <= 1'b0;
      end
    end else if (in_xfer) begin
      if (out_valid && !out_xfer) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) begin
        out_res <= skid_res;
      end
    end else if (in_xfer) begin
      if (out_valid && !out_xfer) begin
        skid_res <= result_new;
      end else begin
        out_res <= result_new;
      end
    end
  end

  assign in_stall = skid_valid;

  // Lamps follow the phase of the result being presented
  assign phase_code  = out_res.phase;
  assign red_lamp    = (out_res.phase == tls_pkg::PH_RED);
  assign yellow_lamp = (out_res.phase == tls_pkg::PH_READY_YELLOW) ||
                       (out_res.phase == tls_pkg::PH_CAUTION_YELLOW);
  assign green_lamp  = (out_res.phase == tls_pkg::PH_GREEN);
  assign buzzer_on   = out_res.buzzer;

endmodule

`default_nettype wire

>>> rtl/tls_checker.sv
// Port-level checker for the traffic light sequencer and its bind.
`default_nettype none

module tls_port_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [1:0]                phase_code,
  input wire logic                      red_lamp,
  input wire logic                      yellow_lamp,
  input wire logic                      green_lamp,
  input wire logic                      buzzer_on
);

  // exactly one lamp lit on every presented result
  a_one_lamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({red_lamp, yellow_lamp, green_lamp}))
    else $error("lamps not one-hot");

  // green and red lamps agree with the phase code
  a_lamp_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (green_lamp == (phase_code == tls_pkg::PH_GREEN)) &&
                  (red_lamp == (phase_code == tls_pkg::PH_RED)))
    else $error("lamps disagree with phase code");

  // the beeper only sounds in green
  a_buzz_green: assert property (@(posedge clk) disable iff (rst)
    (out_valid && buzzer_on) |-> green_lamp)
    else $error("buzzer on outside green");

  // input is held off only while a result waits at the output
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && $past(out_valid && out_stall))
    else $error("input stalled with no pending result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(phase_code) &&
                                 $stable(buzzer_on))
    else $error("stalled result changed");

endmodule

bind traffic_light_sequencer_core tls_port_checker u_tls_port_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .phase_code  (phase_code),
  .red_lamp    (red_lamp),
  .yellow_lamp (yellow_lamp),
  .green_lamp  (green_lamp),
  .buzzer_on   (buzzer_on)
);

`default_nettype wire

>>> tb/tls_checker.sv
// Checker for the traffic light sequencer: predicts each step and compares every result.
`timescale 1ns / 100ps

module tls_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      time_step,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [1:0]                phase_code,
  input  logic                      red_lamp,
  input  logic                      yellow_lamp,
  input  logic                      green_lamp,
  input  logic                      buzzer_on,
  input  logic                      cfg_we,
  input  logic [tls_pkg::IdxW-1:0]  cfg_index,
  input  logic [tls_pkg::CntW-1:0]  cfg_data,
  output int                        fail_count,
  output int                        pending,
  output int                        results_seen,
  output int                        beeps_seen
);

  typedef struct packed {
    logic [1:0] phase_code;
    logic       red;
    logic       yellow;
    logic       green;
    logic       buzzer;
  } lamps_t;

  lamps_t lamps_q[$];

  // Timing registers as the block should hold them
  logic [tls_pkg::CntW-1:0] phase_len [4];
  logic [tls_pkg::CntW-1:0] beep_period;
  logic [tls_pkg::CntW-1:0] beep_length;

  // Light state
  tls_pkg::phase_t          ph;
  logic [tls_pkg::CntW-1:0] elapsed;
  logic [tls_pkg::CntW-1:0] since_beep;
  logic                     beep_armed;
  logic                     buzz;

  int errs  = 0;
  int got   = 0;
  int beeps = 0;

  function automatic logic [tls_pkg::CntW-1:0] bump(input logic [tls_pkg::CntW-1:0] v);
    return (v == tls_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errs++;
    end
  endtask

  // One step of the light: tick, beep start, beep end, then phase end.
  task automatic advance_light(input logic ts, output lamps_t res);
    logic [1:0] nxt;
    if (ts) begin
      elapsed = bump(elapsed);
      if (beep_armed) since_beep = bump(since_beep);
    end
    if (ph == tls_pkg::PH_GREEN) begin
      if (!beep_armed || since_beep >= beep_period) begin
        buzz       = 1'b1;
        since_beep = '0;
        beep_armed = 1'b1;
      end
      if (buzz && since_beep >= beep_length) buzz = 1'b0;
    end
    if (elapsed >= phase_len[ph]) begin
      nxt        = ph + 2'd1;
      ph         = tls_pkg::phase_t'(nxt);
      elapsed    = '0;
      since_beep = '0;
      beep_armed = 1'b0;
      buzz       = 1'b0;
    end
    res.phase_code = ph;
    res.red        = (ph == tls_pkg::PH_RED);
    res.yellow     = (ph == tls_pkg::PH_READY_YELLOW) || (ph == tls_pkg::PH_CAUTION_YELLOW);
    res.green      = (ph == tls_pkg::PH_GREEN);
    res.buzzer     = buzz;
  endtask

  always @(posedge clk) begin
    lamps_t want;
    lamps_t res;
    if (rst) begin
      phase_len[tls_pkg::PH_RED]            = tls_pkg::RST_RED_MS;
      phase_len[tls_pkg::PH_READY_YELLOW]   = tls_pkg::RST_READY_YELLOW_MS;
      phase_len[tls_pkg::PH_GREEN]          = tls_pkg::RST_GREEN_MS;
      phase_len[tls_pkg::PH_CAUTION_YELLOW] = tls_pkg::RST_CAUTION_YELLOW_MS;
      beep_period = tls_pkg::RST_BEEP_PERIOD_MS;
      beep_length = tls_pkg::RST_BEEP_LENGTH_MS;
      ph          = tls_pkg::PH_RED;
      elapsed     = '0;
      since_beep  = '0;
      beep_armed  = 1'b0;
      buzz        = 1'b0;
      lamps_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got++;
        if (buzzer_on) beeps++;
        if (lamps_q.size() == 0) begin
          $error("result transfer with no step outstanding: phase_code %0d", phase_code);
          errs++;
        end else begin
          want = lamps_q.pop_front();
          check_field("phase_code",  32'(want.phase_code), 32'(phase_code));
          check_field("red_lamp",    32'(want.red),        32'(red_lamp));
          check_field("yellow_lamp", 32'(want.yellow),     32'(yellow_lamp));
          check_field("green_lamp",  32'(want.green),      32'(green_lamp));
          check_field("buzzer_on",   32'(want.buzzer),     32'(buzzer_on));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          tls_pkg::REG_RED_MS:            phase_len[tls_pkg::PH_RED]            = cfg_data;
          tls_pkg::REG_READY_YELLOW_MS:   phase_len[tls_pkg::PH_READY_YELLOW]   = cfg_data;
          tls_pkg::REG_GREEN_MS:          phase_len[tls_pkg::PH_GREEN]          = cfg_data;
          tls_pkg::REG_CAUTION_YELLOW_MS: phase_len[tls_pkg::PH_CAUTION_YELLOW] = cfg_data;
          tls_pkg::REG_BEEP_PERIOD_MS:    beep_period = cfg_data;
          tls_pkg::REG_BEEP_LENGTH_MS:    beep_length = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_light(time_step, res);
        lamps_q.push_back(res);
      end
    end
    fail_count   <= errs;
    pending      <= lamps_q.size();
    results_seen <= got;
    beeps_seen   <= beeps;
  end

endmodule

>>> tb/tb.sv
// Top of the traffic light sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;

  // Cycles with no transfer at all before the run is declared hung
  localparam int WATCHDOG_LIMIT = 1000;

  // Indexes past the six timing registers; writes there must be dropped
  localparam logic [tls_pkg::IdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [tls_pkg::IdxW-1:0] REG_SPARE_B = 3'd7;

  // Length of the green hold with the longest green and beep lengths
  localparam int HOLD_STEPS = 40;

  typedef logic [tls_pkg::CntW-1:0] cnt_t;

  typedef struct {
    cnt_t red;
    cnt_t ready_yellow;
    cnt_t green;
    cnt_t caution_yellow;
    cnt_t beep_period;
    cnt_t beep_length;
  } timing_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic                     time_step = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               phase_code;
  logic                     red_lamp;
  logic                     yellow_lamp;
  logic                     green_lamp;
  logic                     buzzer_on;
  logic                     cfg_we    = 1'b0;
  logic [tls_pkg::IdxW-1:0] cfg_index = '0;
  logic [tls_pkg::CntW-1:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int results_seen;
  int beeps_seen;

  // Idling knobs; both are dropped for the closing part of the run
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;

  int steps_sent    = 0;
  int timings_used  = 0;
  int quiet_cycles  = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  traffic_light_sequencer_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .time_step   (time_step),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .phase_code  (phase_code),
    .red_lamp    (red_lamp),
    .yellow_lamp (yellow_lamp),
    .green_lamp  (green_lamp),
    .buzzer_on   (buzzer_on),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  tls_checker CHK (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .time_step    (time_step),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .phase_code   (phase_code),
    .red_lamp     (red_lamp),
    .yellow_lamp  (yellow_lamp),
    .green_lamp   (green_lamp),
    .buzzer_on    (buzzer_on),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .beeps_seen   (beeps_seen)
  );

  // Receiver side: stall in random bursts, with open stretches in between.
  // Stall is only ever raised or dropped once per edge.
  always begin
    @(posedge clk);
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  // Watchdog: count cycles in which no transfer of any kind happens.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("** traffic_light_sequencer_core: FAILED **");
      $finish;
    end
  end

  // Present one step and hold it until the transfer happens. An optional
  // idle burst goes in front, so gaps land on every phase of the light.
  task automatic send(input logic ts);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    time_step <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    steps_sent++;
  endtask

  // Drop valid and hold off until every outstanding result has come back,
  // then let the output stage go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One register write; write enable stays up so writes can go back to back.
  task automatic put_reg(input logic [tls_pkg::IdxW-1:0] idx, input cnt_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Load all six timing registers, plus two writes to unused indexes.
  task automatic load_timing(input timing_t t);
    put_reg(tls_pkg::REG_RED_MS,            t.red);
    put_reg(REG_SPARE_A,                    cnt_t'($urandom_range(0, 65535)));
    put_reg(tls_pkg::REG_READY_YELLOW_MS,   t.ready_yellow);
    put_reg(tls_pkg::REG_GREEN_MS,          t.green);
    put_reg(tls_pkg::REG_CAUTION_YELLOW_MS, t.caution_yellow);
    put_reg(tls_pkg::REG_BEEP_PERIOD_MS,    t.beep_period);
    put_reg(REG_SPARE_B,                    cnt_t'($urandom_range(0, 65535)));
    put_reg(tls_pkg::REG_BEEP_LENGTH_MS,    t.beep_length);
    cfg_we <= 1'b0;
    timings_used++;
  endtask

  // Mode 0 gives zero, mode 1 zero or full scale; otherwise mostly short lengths
  // so the light cycles; now and then zero or any 16-bit value, which may park it.
  function automatic cnt_t pick_ms(input int mode);
    int r;
    r = $urandom_range(0, 15);
    if (mode == 0) return '0;
    if (mode == 1) return ($urandom_range(0, 1) != 0) ? tls_pkg::CNT_MAX : '0;
    if (r < 2) return '0;
    if (r == 2) return cnt_t'($urandom_range(0, 65535));
    return cnt_t'($urandom_range(1, 9));
  endfunction

  initial begin
    timing_t    t;
    logic [9:0] pattern;
    int         mode;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset timing: red must be lit from the first step, with or without a tick.
    send(1'b0);
    send(1'b1);
    send(1'b1);

    // Zero-length red and caution, zero beep period and zero beep length:
    // red falls through at once, and the buzzer never shows in green.
    settle();
    t = '{16'd0, 16'd1, 16'd5, 16'd0, 16'd0, 16'd0};
    load_timing(t);
    pattern = 10'b1111101010;
    for (int i = 0; i < 10; i++) send(pattern[i]);

    // Ordinary beeping: period 3, length 2, with polls mixed between ticks.
    settle();
    t = '{16'd2, 16'd0, 16'd8, 16'd1, 16'd3, 16'd2};
    load_timing(t);
    pattern = 10'b1101111011;
    for (int i = 0; i < 10; i++) send(pattern[i]);

    // Long green: a green length of 65535 holds the light in green, and a
    // beep length beyond the period keeps the buzzer on across restarts.
    settle();
    t = '{16'd0, 16'd0, tls_pkg::CNT_MAX, 16'd2, 16'd3, tls_pkg::CNT_MAX};
    load_timing(t);
    repeat (HOLD_STEPS) send(1'b1);

    // Zero, full-scale and random timings; every round starts from a fully drained block.
    for (int r = 0; r < 8; r++) begin
      settle();
      if (r >= 6) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      if (r == 0) mode = 0;
      else if (r == 1) mode = 1;
      else mode = 2;
      t = '{pick_ms(mode), pick_ms(mode), pick_ms(mode),
            pick_ms(mode), pick_ms(mode), pick_ms(mode)};
      load_timing(t);
      repeat (70) send($urandom_range(0, 4) != 0);
    end

    settle();

    $display("Sent %0d steps under %0d timing settings (zero, full-scale and random lengths),",
             steps_sent, timings_used);
    $display("checked %0d results, %0d of them with the buzzer sounding.",
             results_seen, beeps_seen);
    if (fail_count == 0 && pending == 0)
      $display("** traffic_light_sequencer_core: PASSED **");
    else
      $display("** traffic_light_sequencer_core: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
rtl/tls_pkg.sv
rtl/traffic_light_sequencer_core.sv
rtl/tls_checker.sv
tb/tls_checker.sv
tb/tb.sv
